FILE: hw/rtl/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// Shared constants, micro-op codes and saturation helpers for the 2x2
// steepest descent solver.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int ACC_W = 66;
    localparam int OP_W  = 5;
    localparam int REG_W = 3;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam logic [OP_W-1:0] OP_TOL  = 5'd0;
    localparam logic [OP_W-1:0] OP_R1A  = 5'd1;
    localparam logic [OP_W-1:0] OP_R1B  = 5'd2;
    localparam logic [OP_W-1:0] OP_R2A  = 5'd3;
    localparam logic [OP_W-1:0] OP_R2B  = 5'd4;
    localparam logic [OP_W-1:0] OP_RR1  = 5'd5;
    localparam logic [OP_W-1:0] OP_RR2  = 5'd6;
    localparam logic [OP_W-1:0] OP_AR1A = 5'd7;
    localparam logic [OP_W-1:0] OP_AR1B = 5'd8;
    localparam logic [OP_W-1:0] OP_AR2A = 5'd9;
    localparam logic [OP_W-1:0] OP_AR2B = 5'd10;
    localparam logic [OP_W-1:0] OP_DN1  = 5'd11;
    localparam logic [OP_W-1:0] OP_DN2  = 5'd12;
    localparam logic [OP_W-1:0] OP_UP1  = 5'd13;
    localparam logic [OP_W-1:0] OP_UP2  = 5'd14;
    localparam logic [OP_W-1:0] OP_OX1A = 5'd15;
    localparam logic [OP_W-1:0] OP_OX1B = 5'd16;
    localparam logic [OP_W-1:0] OP_OX2A = 5'd17;
    localparam logic [OP_W-1:0] OP_OX2B = 5'd18;
    localparam logic [OP_W-1:0] OP_OF1  = 5'd19;
    localparam logic [OP_W-1:0] OP_OF2  = 5'd20;
    localparam logic [OP_W-1:0] OP_OF3  = 5'd21;
    localparam logic [OP_W-1:0] OP_OF4  = 5'd22;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_CURVATURE = 2'd2;

    localparam logic [REG_W-1:0] REG_A11 = 3'd0;
    localparam logic [REG_W-1:0] REG_A12 = 3'd1;
    localparam logic [REG_W-1:0] REG_A21 = 3'd2;
    localparam logic [REG_W-1:0] REG_A22 = 3'd3;
    localparam logic [REG_W-1:0] REG_B1  = 3'd4;
    localparam logic [REG_W-1:0] REG_B2  = 3'd5;
    localparam logic [REG_W-1:0] REG_C   = 3'd6;
    localparam logic [REG_W-1:0] REG_TOL = 3'd7;

    function automatic logic signed [31:0] sat32(input acc_t v);
        if (v > acc_t'(64'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -acc_t'(64'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sat64(input acc_t v);
        if (v[ACC_W-1:63] != {(ACC_W-63){v[63]}}) begin
            return v[ACC_W-1] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return v[63:0];
    endfunction

    function automatic logic signed [47:0] sat48(input acc_t v);
        if (v[ACC_W-1:47] != {(ACC_W-47){v[47]}}) begin
            return v[ACC_W-1] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
        return v[47:0];
    endfunction

endpackage

FILE: hw/rtl/steepest_descent_2x2_solver.sv
`timescale 1ns / 1ps
// Each pass runs its micro-ops on the shared multiplier and a bit-serial divide
// for the step size; a run stops after at most MAX_PASSES passes.
// Throughput: one item at a time, accepted only in idle after the last result; the
// single 32x32 multiplier and the one-bit-per-cycle divider set the pass length.
// Reset: aresetn synchronous, active low; registers return to identity A,
// zero b and c, tolerance 1e-5; no result pending.
// ----------------------------------------------------------------------------
// steepest_descent_2x2_solver
// Minimizes 0.5x'Ax - b'x + c by steepest descent over a shared multiplier.
// ----------------------------------------------------------------------------
module steepest_descent_2x2_solver
    import sds_pkg::*;
#(
    parameter int MAX_PASSES = 1024,
    parameter int FRAC_BITS  = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // start_x1, start_x2
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // min_x1, min_x2, objective_value, passes, status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CNT_W   = $clog2(MAX_PASSES + 1);
    localparam int DIV_W   = ((FRAC_BITS > 31) ? (63 + FRAC_BITS) : 94) + 1;
    localparam int ONE_Q   = 1 << FRAC_BITS;
    localparam int TOL_RST = (ONE_Q + 50000) / 100000;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic signed [31:0] a11_reg, a12_reg, a21_reg, a22_reg, b1_reg, b2_reg, c_reg;
    logic [30:0]        tol_reg;
    logic [2:0]         state_reg;
    logic [OP_W-1:0]    op_reg;
    logic signed [31:0] x1_reg, x2_reg, r1_reg, r2_reg, ar1_reg, ar2_reg, step_reg;
    logic signed [63:0] rr_reg, den_reg, prod_reg;
    logic [61:0]        tol2_reg;
    acc_t               acc_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         status_reg;
    logic signed [47:0] obj_reg;
    logic [DIV_W-1:0]   rem_reg, dsh_reg;
    logic [4:0]         div_cnt_reg;
    logic               m_tvalid_reg;
    logic [127:0]       m_tdata_reg;

    logic signed [31:0] mul_a, mul_b;
    acc_t               p_ext, p_f, p_f1, sum_f, sum_p;
    logic signed [63:0] sum_p64;
    logic               div_ge;
    logic [10:0]        passes_sat;
    logic               cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        case (paddr[4:2])
            REG_A11: prdata = a11_reg;
            REG_A12: prdata = a12_reg;
            REG_A21: prdata = a21_reg;
            REG_A22: prdata = a22_reg;
            REG_B1:  prdata = b1_reg;
            REG_B2:  prdata = b2_reg;
            REG_C:   prdata = c_reg;
            default: prdata = {1'b0, tol_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a11_reg <= 32'(ONE_Q);
            a12_reg <= '0;
            a21_reg <= '0;
            a22_reg <= 32'(ONE_Q);
            b1_reg  <= '0;
            b2_reg  <= '0;
            c_reg   <= '0;
            tol_reg <= 31'(TOL_RST);
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_A11: a11_reg <= pwdata;
                REG_A12: a12_reg <= pwdata;
                REG_A21: a21_reg <= pwdata;
                REG_A22: a22_reg <= pwdata;
                REG_B1:  b1_reg  <= pwdata;
                REG_B2:  b2_reg  <= pwdata;
                REG_C:   c_reg   <= pwdata;
                REG_TOL: tol_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = x1_reg;
        mul_b = x1_reg;
        case (op_reg) inside
            OP_TOL:  begin mul_a = {1'b0, tol_reg}; mul_b = {1'b0, tol_reg}; end
            OP_R1A, OP_OX1A: begin mul_a = a11_reg; mul_b = x1_reg; end
            OP_R1B, OP_OX1B: begin mul_a = a12_reg; mul_b = x2_reg; end
            OP_R2A, OP_OX2A: begin mul_a = a21_reg; mul_b = x1_reg; end
            OP_R2B, OP_OX2B: begin mul_a = a22_reg; mul_b = x2_reg; end
            OP_RR1:  begin mul_a = r1_reg;   mul_b = r1_reg;  end
            OP_RR2:  begin mul_a = r2_reg;   mul_b = r2_reg;  end
            OP_AR1A: begin mul_a = a11_reg;  mul_b = r1_reg;  end
            OP_AR1B: begin mul_a = a12_reg;  mul_b = r2_reg;  end
            OP_AR2A: begin mul_a = a21_reg;  mul_b = r1_reg;  end
            OP_AR2B: begin mul_a = a22_reg;  mul_b = r2_reg;  end
            OP_DN1:  begin mul_a = r1_reg;   mul_b = ar1_reg; end
            OP_DN2:  begin mul_a = r2_reg;   mul_b = ar2_reg; end
            OP_UP1:  begin mul_a = step_reg; mul_b = r1_reg;  end
            OP_UP2:  begin mul_a = step_reg; mul_b = r2_reg;  end
            OP_OF1:  begin mul_a = x1_reg;   mul_b = ar1_reg; end
            OP_OF2:  begin mul_a = x2_reg;   mul_b = ar2_reg; end
            OP_OF3:  begin mul_a = x1_reg;   mul_b = b1_reg;  end
            OP_OF4:  begin mul_a = x2_reg;   mul_b = b2_reg;  end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        p_ext   = acc_t'(prod_reg);
        p_f     = p_ext >>> FRAC_BITS;
        p_f1    = p_ext >>> (FRAC_BITS + 1);
        sum_f   = acc_reg + p_f;
        sum_p   = acc_reg + p_ext;
        sum_p64 = sat64(sum_p);
        div_ge  = (rem_reg >= dsh_reg);
        passes_sat = (32'(count_reg) > 32'd2047) ? 11'h7FF : 11'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_TOL;
            count_reg    <= '0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x1_reg    <= s_tdata[31:0];
                        x2_reg    <= s_tdata[63:32];
                        count_reg <= '0;
                        op_reg    <= OP_TOL;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    state_reg <= S_MUL;
                    op_reg    <= op_reg + 5'd1;
                    case (op_reg) inside
                        OP_TOL: tol2_reg <= prod_reg[61:0];
                        OP_R1A, OP_R2A, OP_AR1A, OP_AR2A, OP_OX1A, OP_OX2A:
                            acc_reg <= p_f;
                        OP_R1B: r1_reg <= sat32(acc_t'(b1_reg) - sum_f);
                        OP_R2B: r2_reg <= sat32(acc_t'(b2_reg) - sum_f);
                        OP_RR1, OP_DN1: acc_reg <= p_ext;
                        OP_RR2: begin
                            rr_reg    <= sum_p64;
                            count_reg <= count_reg + CNT_W'(1);
                            if (sum_p64 == 64'sd0) begin
                                status_reg <= ST_CONVERGED;
                                op_reg     <= OP_OX1A;
                            end
                        end
                        OP_AR1B, OP_OX1B: ar1_reg <= sat32(sum_f);
                        OP_AR2B, OP_OX2B: ar2_reg <= sat32(sum_f);
                        OP_DN2: begin
                            den_reg <= sum_p64;
                            if (sum_p64 <= 64'sd0) begin
                                status_reg <= ST_CURVATURE;
                                op_reg     <= OP_OX1A;
                            end else begin
                                rem_reg     <= DIV_W'(rr_reg) << FRAC_BITS;
                                dsh_reg     <= DIV_W'(sum_p64) << 31;
                                div_cnt_reg <= 5'd31;
                                state_reg   <= S_DIV;
                            end
                        end
                        OP_UP1: x1_reg <= sat32(acc_t'(x1_reg) + p_f);
                        OP_UP2: begin
                            x2_reg <= sat32(acc_t'(x2_reg) + p_f);
                            if ($unsigned(rr_reg) <= {2'b00, tol2_reg}) begin
                                status_reg <= ST_CONVERGED;
                                op_reg     <= OP_OX1A;
                            end else if (count_reg == CNT_W'(MAX_PASSES)) begin
                                status_reg <= ST_LIMIT;
                                op_reg     <= OP_OX1A;
                            end else begin
                                op_reg <= OP_R1A;
                            end
                        end
                        OP_OF1: acc_reg <= p_f1;
                        OP_OF2: acc_reg <= acc_reg + p_f1;
                        OP_OF3: acc_reg <= acc_reg - p_f;
                        OP_OF4: begin
                            obj_reg   <= sat48(acc_reg - p_f + acc_t'(c_reg));
                            state_reg <= S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (div_cnt_reg == 5'd31 && div_ge) begin
                        step_reg  <= 32'sh7FFF_FFFF;
                        op_reg    <= OP_UP1;
                        state_reg <= S_MUL;
                    end else begin
                        if (div_ge) begin
                            rem_reg <= rem_reg - dsh_reg;
                        end
                        step_reg <= {step_reg[30:0], div_ge};
                        dsh_reg  <= dsh_reg >> 1;
                        if (div_cnt_reg == 5'd0) begin
                            op_reg    <= OP_UP1;
                            state_reg <= S_MUL;
                        end else begin
                            div_cnt_reg <= div_cnt_reg - 5'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {3'b000, status_reg, passes_sat, obj_reg, x2_reg, x1_reg};
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");

    a_div_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> (!den_reg[63] && den_reg != 64'sd0))
        else $error("divide started with non-positive curvature");

    a_limit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && status_reg == ST_LIMIT) |-> count_reg == CNT_W'(MAX_PASSES))
        else $error("iteration limit flagged early");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> count_reg <= CNT_W'(MAX_PASSES))
        else $error("pass count overran limit");

endmodule
